### rtl/core/dhd_pkg.sv
// Shared widths, constants, types and step functions of the diffuse direction unit.
package dhd_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W = 16;
	localparam int W_W = 20;
	localparam int LEN_W = 20;
	localparam int Q_W = 16;
	localparam int U_W = 18;
	localparam int XW = 34;
	localparam int SQ_W = 41;
	localparam int DIV_W = 35;
	localparam int SQA_N = 17;
	localparam int SQB_N = 20;
	localparam int ROUND_F = 1 << (FRAC_BITS - 1);

	localparam logic signed [XW-1:0] SKEW_X = XW'(((34 << FRAC_BITS) + 5000) / 10000);
	localparam logic signed [XW-1:0] SKEW_Y = XW'(1) << FRAC_BITS;
	localparam logic signed [XW-1:0] SKEW_Z = XW'(((71 << FRAC_BITS) + 5000) / 10000);
	localparam logic [29:0] INV_PI_Q30 = 30'd341782638;
	localparam logic [15:0] REFL_MAX = 16'd32768;

	typedef enum logic [1:0] {
		REG_GAIN  = 2'd0,
		REG_RED   = 2'd1,
		REG_GREEN = 2'd2,
		REG_BLUE  = 2'd3
	} reg_idx_t;

	// Per-item data that travels alongside the arithmetic units.
	typedef struct packed {
		logic                      vld;
		logic                      deg;
		logic [2:0][IN_W-1:0]      n;
		logic [2:0][IN_W-1:0]      s;
		logic [2:0][W_W-1:0]       vec;
		logic [LEN_W-1:0]          dvs;
	} carry_t;

	typedef struct packed {
		logic [SQ_W-1:0] x;
		logic [SQ_W-1:0] res;
	} sq_t;

	typedef struct packed {
		logic [DIV_W-1:0] r;
		logic [Q_W-1:0]   q;
	} dv_t;

	typedef dv_t [2:0] dv_lanes_t;

	function automatic sq_t sqrt_step(sq_t a, logic [SQ_W-1:0] b);
		sq_t              r;
		logic [SQ_W-1:0]  t;
		t = a.res + b;
		if (a.x >= t) begin
			r.x = a.x - t;
			r.res = (a.res >> 1) + b;
		end else begin
			r.x = a.x;
			r.res = a.res >> 1;
		end
		return r;
	endfunction

	function automatic dv_t div_step(dv_t a, logic [DIV_W-1:0] dsh, logic [Q_W-1:0] qm);
		dv_t r;
		r = a;
		if (a.r >= dsh) begin
			r.r = a.r - dsh;
			r.q = a.q | qm;
		end
		return r;
	endfunction

	// Numerator is |a| * 2^FRAC_BITS plus half the divisor, so the quotient rounds half away.
	function automatic dv_lanes_t div_init(carry_t c, logic [LEN_W-1:0] len);
		dv_lanes_t       r;
		logic [W_W-1:0]  mag;
		for (int i = 0; i < 3; i++) begin
			mag = c.vec[i][W_W-1] ? W_W'(-$signed(c.vec[i])) : c.vec[i];
			r[i].r = (DIV_W'(mag) << FRAC_BITS) + DIV_W'(len >> 1);
			r[i].q = '0;
		end
		return r;
	endfunction

	function automatic logic [2:0][IN_W-1:0] div_result(dv_lanes_t a, carry_t c);
		logic [2:0][IN_W-1:0] r;
		for (int i = 0; i < 3; i++) begin
			r[i] = c.vec[i][W_W-1] ? IN_W'(-$signed(a[i].q)) : IN_W'(a[i].q);
		end
		return r;
	endfunction

endpackage

### rtl/core/diffuse_hemisphere_direction_unit.sv
// Throughput: one transaction per cycle; busy is held low and start may be high every cycle.
// The depth is set by two pipelined square roots (17 and 20 stages) and two lanes-of-three
// pipelined dividers (16 stages each), one result bit per stage.
// Reset clears all valid bits and restores gain to 1.0 and the colors to zero.
// The receiver cannot stall: each result is shown for exactly one cycle.
module diffuse_hemisphere_direction_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic signed [15:0] sample_x,
	input  logic signed [15:0] sample_y,
	input  logic signed [15:0] sample_z,
	output logic               done,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z,
	output logic signed [15:0] density,
	output logic [15:0]        refl_red,
	output logic [15:0]        refl_green,
	output logic [15:0]        refl_blue,
	output logic               degenerate,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int FB = dhd_pkg::FRAC_BITS;
	localparam int IW = dhd_pkg::IN_W;
	localparam int WW = dhd_pkg::W_W;
	localparam int LW = dhd_pkg::LEN_W;
	localparam int QW = dhd_pkg::Q_W;
	localparam int UW = dhd_pkg::U_W;
	localparam int XW = dhd_pkg::XW;
	localparam int SW = dhd_pkg::SQ_W;
	localparam int DW = dhd_pkg::DIV_W;
	localparam int NA = dhd_pkg::SQA_N;
	localparam int NB = dhd_pkg::SQB_N;

	// ---------------- configuration registers ----------------
	logic [15:0] gain_q, red_q, green_q, blue_q;

	assign pready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 16'd32768;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (dhd_pkg::reg_idx_t'(paddr[3:2]))
				dhd_pkg::REG_GAIN:  gain_q <= pwdata[15:0];
				dhd_pkg::REG_RED:   red_q <= pwdata[15:0];
				dhd_pkg::REG_GREEN: green_q <= pwdata[15:0];
				dhd_pkg::REG_BLUE:  blue_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (dhd_pkg::reg_idx_t'(paddr[3:2]))
			dhd_pkg::REG_GAIN:  prdata = {16'd0, gain_q};
			dhd_pkg::REG_RED:   prdata = {16'd0, red_q};
			dhd_pkg::REG_GREEN: prdata = {16'd0, green_q};
			dhd_pkg::REG_BLUE:  prdata = {16'd0, blue_q};
			default:            prdata = '0;
		endcase
	end

	// Reflectance depends only on the registers, so it is computed free-running.
	logic [15:0] col   [3];
	logic [31:0] rp_q  [3];
	logic [15:0] rf_q  [3];
	logic [61:0] rprod [3];
	logic [16:0] rquo  [3];

	assign col[0] = red_q;
	assign col[1] = green_q;
	assign col[2] = blue_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rprod[c] = 62'(rp_q[c]) * 62'(dhd_pkg::INV_PI_Q30);
			rquo[c] = 17'((rprod[c] + (62'(1) << 44)) >> 45);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				rp_q[c] <= '0;
				rf_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < 3; c++) begin
				rp_q[c] <= 32'(col[c]) * 32'(gain_q);
				rf_q[c] <= (rquo[c] > 17'(dhd_pkg::REFL_MAX)) ? dhd_pkg::REFL_MAX : rquo[c][15:0];
			end
		end
	end

	// ---------------- front: input, v = skew x n, squares ----------------
	dhd_pkg::carry_t c_s1, c_s2, c_s3, c_s4;
	logic [SW-1:0]   vsq_s3 [3];
	dhd_pkg::sq_t    sqa0_s4;

	dhd_pkg::carry_t c1_d, c2_d;
	logic signed [XW-1:0] nx [3];
	logic signed [XW-1:0] xr [3];
	logic signed [XW-1:0] vt [3];
	logic signed [2*WW-1:0] vs [3];

	always_comb begin
		c1_d = '0;
		c1_d.vld = start;
		c1_d.n = {normal_z, normal_y, normal_x};
		c1_d.s = {sample_z, sample_y, sample_x};
		for (int i = 0; i < 3; i++) begin
			nx[i] = XW'($signed(c_s1.n[i]));
		end
		xr[0] = dhd_pkg::SKEW_Y * nx[2] - dhd_pkg::SKEW_Z * nx[1];
		xr[1] = dhd_pkg::SKEW_Z * nx[0] - dhd_pkg::SKEW_X * nx[2];
		xr[2] = dhd_pkg::SKEW_X * nx[1] - dhd_pkg::SKEW_Y * nx[0];
		c2_d = c_s1;
		for (int i = 0; i < 3; i++) begin
			vt[i] = (xr[i] + XW'(dhd_pkg::ROUND_F)) >>> FB;
			c2_d.vec[i] = WW'(vt[i]);
			vs[i] = $signed(c_s2.vec[i]) * $signed(c_s2.vec[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			c_s2 <= '0;
			c_s3 <= '0;
			c_s4 <= '0;
			sqa0_s4 <= '0;
			for (int i = 0; i < 3; i++) vsq_s3[i] <= '0;
		end else begin
			c_s1 <= c1_d;
			c_s2 <= c2_d;
			c_s3 <= c_s2;
			for (int i = 0; i < 3; i++) vsq_s3[i] <= SW'($unsigned(vs[i]));
			c_s4 <= c_s3;
			sqa0_s4.x <= vsq_s3[0] + vsq_s3[1] + vsq_s3[2];
			sqa0_s4.res <= '0;
		end
	end

	// ---------------- first square root ----------------
	dhd_pkg::sq_t    sqa_s [1:NA];
	dhd_pkg::carry_t ca_s  [1:NA];

	for (genvar k = 0; k < NA; k++) begin : g_sqa
		localparam logic [SW-1:0] SBIT = SW'(1) << (2 * (NA - 1 - k));
		dhd_pkg::sq_t    sq_in;
		dhd_pkg::carry_t c_in;
		if (k == 0) begin : g_head
			assign sq_in = sqa0_s4;
			assign c_in = c_s4;
		end else begin : g_body
			assign sq_in = sqa_s[k];
			assign c_in = ca_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqa_s[k+1] <= '0;
				ca_s[k+1] <= '0;
			end else begin
				sqa_s[k+1] <= dhd_pkg::sqrt_step(sq_in, SBIT);
				ca_s[k+1] <= c_in;
			end
		end
	end

	// ---------------- first divider: v / |v| ----------------
	logic [LW-1:0]         len_a;
	dhd_pkg::carry_t       cda_d;
	dhd_pkg::carry_t       cda_s0;
	dhd_pkg::dv_lanes_t    dva_s0;
	dhd_pkg::dv_lanes_t    dva_s [1:QW];
	dhd_pkg::carry_t       cda_s [1:QW];

	assign len_a = sqa_s[NA].res[LW-1:0];

	always_comb begin
		cda_d = ca_s[NA];
		cda_d.dvs = len_a;
		cda_d.deg = (len_a == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cda_s0 <= '0;
			dva_s0 <= '0;
		end else begin
			cda_s0 <= cda_d;
			dva_s0 <= dhd_pkg::div_init(ca_s[NA], len_a);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_dva
		localparam logic [QW-1:0] QM = QW'(1) << (QW - 1 - k);
		dhd_pkg::dv_lanes_t d_in;
		dhd_pkg::carry_t    c_in;
		logic [DW-1:0]      dsh;
		if (k == 0) begin : g_head
			assign d_in = dva_s0;
			assign c_in = cda_s0;
		end else begin : g_body
			assign d_in = dva_s[k];
			assign c_in = cda_s[k];
		end
		assign dsh = DW'(c_in.dvs) << (QW - 1 - k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dva_s[k+1] <= '0;
				cda_s[k+1] <= '0;
			end else begin
				for (int l = 0; l < 3; l++) dva_s[k+1][l] <= dhd_pkg::div_step(d_in[l], dsh, QM);
				cda_s[k+1] <= c_in;
			end
		end
	end

	// ---------------- u = v x n, then w = u*sx + v*sy + n*sz ----------------
	logic [2:0][IW-1:0]    vn;
	dhd_pkg::carry_t       c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	logic signed [31:0]    up_s5 [6];
	logic signed [UW-1:0]  u_s6 [3];
	logic signed [33:0]    wp_s7 [3][3];
	logic [SW-1:0]         wsq_s9 [3];
	dhd_pkg::sq_t          sqb0_s10;

	dhd_pkg::carry_t       c5_d, c8_d;
	logic signed [IW-1:0]  vq [3];
	logic signed [IW-1:0]  nq [3];
	logic signed [33:0]    ud [3];
	logic signed [IW-1:0]  v6 [3];
	logic signed [IW-1:0]  n6 [3];
	logic signed [IW-1:0]  s6 [3];
	logic signed [35:0]    wsum [3];
	logic signed [2*WW-1:0] ws [3];

	assign vn = dhd_pkg::div_result(dva_s[QW], cda_s[QW]);

	always_comb begin
		c5_d = cda_s[QW];
		c8_d = c_s7;
		for (int i = 0; i < 3; i++) begin
			vq[i] = $signed(vn[i]);
			nq[i] = $signed(cda_s[QW].n[i]);
			ud[i] = (34'(up_s5[2*i]) - 34'(up_s5[2*i+1]) + 34'(dhd_pkg::ROUND_F)) >>> FB;
			v6[i] = $signed(c_s6.vec[i][IW-1:0]);
			n6[i] = $signed(c_s6.n[i]);
			s6[i] = $signed(c_s6.s[i]);
			wsum[i] = 36'(wp_s7[i][0]) + 36'(wp_s7[i][1]) + 36'(wp_s7[i][2])
				+ 36'(dhd_pkg::ROUND_F);
			ws[i] = $signed(c_s8.vec[i]) * $signed(c_s8.vec[i]);
			c5_d.vec[i] = WW'(vq[i]);
			c8_d.vec[i] = WW'(wsum[i] >>> FB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s5 <= '0;
			c_s6 <= '0;
			c_s7 <= '0;
			c_s8 <= '0;
			c_s9 <= '0;
			c_s10 <= '0;
			sqb0_s10 <= '0;
			for (int i = 0; i < 6; i++) up_s5[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				u_s6[i] <= '0;
				wsq_s9[i] <= '0;
				for (int j = 0; j < 3; j++) wp_s7[i][j] <= '0;
			end
		end else begin
			c_s5 <= c5_d;
			up_s5[0] <= 32'(vq[1]) * 32'(nq[2]);
			up_s5[1] <= 32'(vq[2]) * 32'(nq[1]);
			up_s5[2] <= 32'(vq[2]) * 32'(nq[0]);
			up_s5[3] <= 32'(vq[0]) * 32'(nq[2]);
			up_s5[4] <= 32'(vq[0]) * 32'(nq[1]);
			up_s5[5] <= 32'(vq[1]) * 32'(nq[0]);

			c_s6 <= c_s5;
			for (int i = 0; i < 3; i++) u_s6[i] <= UW'(ud[i]);

			c_s7 <= c_s6;
			for (int i = 0; i < 3; i++) begin
				wp_s7[i][0] <= 34'(s6[0]) * 34'(u_s6[i]);
				wp_s7[i][1] <= 34'(s6[1]) * 34'(v6[i]);
				wp_s7[i][2] <= 34'(s6[2]) * 34'(n6[i]);
			end

			c_s8 <= c8_d;

			c_s9 <= c_s8;
			for (int i = 0; i < 3; i++) wsq_s9[i] <= SW'($unsigned(ws[i]));

			c_s10 <= c_s9;
			sqb0_s10.x <= wsq_s9[0] + wsq_s9[1] + wsq_s9[2];
			sqb0_s10.res <= '0;
		end
	end

	// ---------------- second square root ----------------
	dhd_pkg::sq_t    sqb_s [1:NB];
	dhd_pkg::carry_t cb_s  [1:NB];

	for (genvar k = 0; k < NB; k++) begin : g_sqb
		localparam logic [SW-1:0] SBIT = SW'(1) << (2 * (NB - 1 - k));
		dhd_pkg::sq_t    sq_in;
		dhd_pkg::carry_t c_in;
		if (k == 0) begin : g_head
			assign sq_in = sqb0_s10;
			assign c_in = c_s10;
		end else begin : g_body
			assign sq_in = sqb_s[k];
			assign c_in = cb_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqb_s[k+1] <= '0;
				cb_s[k+1] <= '0;
			end else begin
				sqb_s[k+1] <= dhd_pkg::sqrt_step(sq_in, SBIT);
				cb_s[k+1] <= c_in;
			end
		end
	end

	// ---------------- second divider: w / |w| ----------------
	logic [LW-1:0]         len_b;
	dhd_pkg::carry_t       cdb_d;
	dhd_pkg::carry_t       cdb_s0;
	dhd_pkg::dv_lanes_t    dvb_s0;
	dhd_pkg::dv_lanes_t    dvb_s [1:QW];
	dhd_pkg::carry_t       cdb_s [1:QW];

	assign len_b = sqb_s[NB].res[LW-1:0];

	always_comb begin
		cdb_d = cb_s[NB];
		cdb_d.dvs = len_b;
		cdb_d.deg = cb_s[NB].deg || (len_b == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cdb_s0 <= '0;
			dvb_s0 <= '0;
		end else begin
			cdb_s0 <= cdb_d;
			dvb_s0 <= dhd_pkg::div_init(cb_s[NB], len_b);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_dvb
		localparam logic [QW-1:0] QM = QW'(1) << (QW - 1 - k);
		dhd_pkg::dv_lanes_t d_in;
		dhd_pkg::carry_t    c_in;
		logic [DW-1:0]      dsh;
		if (k == 0) begin : g_head
			assign d_in = dvb_s0;
			assign c_in = cdb_s0;
		end else begin : g_body
			assign d_in = dvb_s[k];
			assign c_in = cdb_s[k];
		end
		assign dsh = DW'(c_in.dvs) << (QW - 1 - k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvb_s[k+1] <= '0;
				cdb_s[k+1] <= '0;
			end else begin
				for (int l = 0; l < 3; l++) dvb_s[k+1][l] <= dhd_pkg::div_step(d_in[l], dsh, QM);
				cdb_s[k+1] <= c_in;
			end
		end
	end

	// ---------------- density = dot(n, d) / pi ----------------
	// The quotient never exceeds 1.0, so the direction needs no clamp of its own.
	dhd_pkg::carry_t       c_s11, c_s12, c_s13, c_s14;
	logic [2:0][IW-1:0]    d_s11, d_s12, d_s13, d_s14;
	logic signed [31:0]    dp_s12 [3];
	logic signed [31:0]    dot_s13;
	logic signed [61:0]    dm_s14;

	logic signed [IW-1:0]  dq [3];
	logic signed [IW-1:0]  nd [3];
	logic signed [33:0]    dsum;
	logic signed [17:0]    dens_w;
	logic signed [IW-1:0]  dens_sat;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dq[i] = $signed(d_s11[i]);
			nd[i] = $signed(c_s11.n[i]);
		end
		dsum = 34'(dp_s12[0]) + 34'(dp_s12[1]) + 34'(dp_s12[2]);
		dens_w = 18'((dm_s14 + (62'(1) << 43)) >>> 44);
		if (dens_w > 18'sd32767) begin
			dens_sat = 16'sh7FFF;
		end else if (dens_w < -18'sd32768) begin
			dens_sat = -16'sh8000;
		end else begin
			dens_sat = IW'(dens_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s11 <= '0;
			c_s12 <= '0;
			c_s13 <= '0;
			c_s14 <= '0;
			d_s11 <= '0;
			d_s12 <= '0;
			d_s13 <= '0;
			d_s14 <= '0;
			for (int i = 0; i < 3; i++) dp_s12[i] <= '0;
			dot_s13 <= '0;
			dm_s14 <= '0;
		end else begin
			c_s11 <= cdb_s[QW];
			d_s11 <= dhd_pkg::div_result(dvb_s[QW], cdb_s[QW]);
			c_s12 <= c_s11;
			d_s12 <= d_s11;
			for (int i = 0; i < 3; i++) dp_s12[i] <= 32'(nd[i]) * 32'(dq[i]);
			c_s13 <= c_s12;
			d_s13 <= d_s12;
			dot_s13 <= 32'(dsum);
			c_s14 <= c_s13;
			d_s14 <= d_s13;
			dm_s14 <= 62'(dot_s13) * 62'(dhd_pkg::INV_PI_Q30);
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			dir_x <= '0;
			dir_y <= '0;
			dir_z <= '0;
			density <= '0;
			refl_red <= '0;
			refl_green <= '0;
			refl_blue <= '0;
			degenerate <= 1'b0;
		end else begin
			done <= c_s14.vld;
			if (c_s14.vld) begin
				if (c_s14.deg) begin
					dir_x <= '0;
					dir_y <= '0;
					dir_z <= '0;
					density <= '0;
					refl_red <= '0;
					refl_green <= '0;
					refl_blue <= '0;
					degenerate <= 1'b1;
				end else begin
					dir_x <= $signed(d_s14[0]);
					dir_y <= $signed(d_s14[1]);
					dir_z <= $signed(d_s14[2]);
					density <= dens_sat;
					refl_red <= rf_q[0];
					refl_green <= rf_q[1];
					refl_blue <= rf_q[2];
					degenerate <= 1'b0;
				end
			end
		end
	end

	// ---------------- assertions ----------------
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> dir_x == '0 && dir_y == '0 && dir_z == '0 && density == '0
			&& refl_red == '0 && refl_green == '0 && refl_blue == '0)
		else $error("degenerate transaction carries nonzero fields");

	a_dir_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |-> dir_x <= 16'sd16384 && dir_x >= -16'sd16384
			&& dir_y <= 16'sd16384 && dir_y >= -16'sd16384
			&& dir_z <= 16'sd16384 && dir_z >= -16'sd16384)
		else $error("normalized direction component exceeds one");

	a_refl_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> refl_red <= dhd_pkg::REFL_MAX && refl_green <= dhd_pkg::REFL_MAX
			&& refl_blue <= dhd_pkg::REFL_MAX)
		else $error("reflectance above saturation limit");

endmodule
